// ===== sv/uvs_pkg.sv =====
package uvs_pkg;

    localparam int MAX_RES_DEFAULT = 1024;

    // quotient bits of a grid fraction (65536 = 1.0 needs 17 bits)
    localparam int FRAC_W   = 17;
    localparam int PHASE_W  = 16;
    localparam int QTR_W    = 14;
    localparam int QUARTER  = 16384;
    localparam int ONE_Q16  = 65536;

    // stages after the divider: fold, square, 4 x Horner, final mul,
    // sign, cross product, round, radius mul, output
    localparam int POST_STAGES = 12;
    localparam int LATENCY     = 2 + FRAC_W + POST_STAGES;

    // odd polynomial for sin(pi/2 * x), Q30
    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598668;
    localparam logic [30:0] SIN_C5 = 31'd85569305;
    localparam logic [30:0] SIN_C7 = 31'd5026996;
    localparam logic [30:0] SIN_C9 = 31'd172272;

    localparam logic [30:0] HORNER_C [4] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

    typedef enum logic [2:0] {
        REG_GRID_RES = 3'd0,
        REG_RADIUS   = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_CENTER_Z = 3'd4,
        REG_HEMI     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [9:0] u_index;
        logic [9:0] v_index;
    } grid_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
    } vertex_t;

    // right shift, rounding half away from zero
    function automatic logic signed [63:0] round_shr(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic [63:0] half;
        logic [63:0] mag;
        half = 64'd1 << (sh - 1);
        mag  = v[63] ? (64'd0 - v) : v;
        mag  = (mag + half) >> sh;
        return v[63] ? $signed(64'd0 - mag) : $signed(mag);
    endfunction

    function automatic logic signed [15:0] sat_q15(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -64'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/uvs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Needs num / den < 2**Q_W.
module uvs_div
    import uvs_pkg::*;
#(
    parameter int D_W = 10,
    parameter int Q_W = FRAC_W
)
(
    input  logic               clk,
    input  logic [D_W+Q_W-1:0] num,
    input  logic [D_W-1:0]     den,
    output logic [Q_W-1:0]     quo
);

    logic [D_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0] low_reg [Q_W];
    logic [Q_W-1:0] quo_reg [Q_W];

    for (genvar g = 0; g < Q_W; g++)
    begin : g_step
        logic [D_W-1:0] rem_in;
        logic [Q_W-1:0] low_in;
        logic [Q_W-1:0] quo_in;
        logic [D_W:0]   trial;
        logic           take;
        logic [D_W-1:0] rem_next;
        logic [Q_W-1:0] low_next;
        logic [Q_W-1:0] quo_next;

        if (g == 0)
        begin : g_first
            assign rem_in = num[D_W+Q_W-1:Q_W];
            assign low_in = num[Q_W-1:0];
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign low_in = low_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        always_comb
        begin
            trial    = {rem_in, low_in[Q_W-1]};
            take     = (trial >= {1'b0, den});
            rem_next = take ? D_W'(trial - {1'b0, den}) : D_W'(trial);
            low_next = {low_in[Q_W-2:0], 1'b0};
            quo_next = {quo_in[Q_W-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g] <= rem_next;
            low_reg[g] <= low_next;
            quo_reg[g] <= quo_next;
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

// ===== sv/uv_sphere_vertex_eval.sv =====
// UV sphere vertex evaluator.
// Input channel: grid_item (u_index, v_index) is taken at a clock edge with
//   start high and busy low. busy stays low: one item per clock, sustained.
// Result channel: vertex (position Q16.16, normal Q1.15, texture Q1.16) is
//   shown for one cycle with done high. The receiver cannot stall; every
//   result must be taken in the cycle it appears.
// Pipeline from accept to done: 2 input/clamp stages, 17 divider stages for
//   the grid fractions, 12 stages of sine polynomial, products and rounding.
//   The 17-step fraction divider and the Horner multiplier chain set the
//   depth; every stage takes a new item each clock.
// Config: wr_en/wr_index/wr_data write one register per clock, no read-back.
//   Write only while no item is in flight. Unknown indexes are dropped.
// Reset (rst_n low, async): pipeline valid bits clear, registers return to
//   resolution 50, radius 1.0, center 0, full sphere. No items are lost or
//   made up by reset beyond those in flight, which are dropped.
module uv_sphere_vertex_eval
    import uvs_pkg::*;
#(
    parameter int MAX_RESOLUTION = MAX_RES_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  grid_item_t grid_item,
    output logic       done,
    output vertex_t    vertex,
    input  logic       wr_en,
    input  logic [2:0] wr_index,
    input  logic [31:0] wr_data
);

    localparam int D_W   = $clog2(MAX_RESOLUTION);
    localparam int RES_W = ($clog2(MAX_RESOLUTION + 1) > 11) ? $clog2(MAX_RESOLUTION + 1) : 11;
    localparam int CMP_W = (D_W > 10) ? D_W : 10;
    localparam int N_W   = D_W + FRAC_W;

    // ---------------- configuration registers ----------------
    logic [10:0]        res_reg;
    logic [30:0]        radius_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] cz_reg;
    logic               hemi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg    <= 11'd50;
            radius_reg <= 31'd65536;
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            hemi_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_GRID_RES: res_reg    <= wr_data[10:0];
                REG_RADIUS:   radius_reg <= wr_data[30:0];
                REG_CENTER_X: cx_reg     <= wr_data;
                REG_CENTER_Y: cy_reg     <= wr_data;
                REG_CENTER_Z: cz_reg     <= wr_data;
                REG_HEMI:     hemi_reg   <= wr_data[0];
                default:      ;
            endcase
        end
    end

    // clamped resolution -> step divisor d = res - 1 (the user keeps it static while items run; not enforced here)
    logic [RES_W-1:0] res_w;
    logic [RES_W-1:0] res_c;
    logic [D_W-1:0]   d_val;

    always_comb
    begin
        res_w = RES_W'(res_reg);
        priority if (res_w < RES_W'(2))
        begin
            res_c = RES_W'(2);
        end
        else if (res_w > RES_W'(MAX_RESOLUTION))
        begin
            res_c = RES_W'(MAX_RESOLUTION);
        end
        else
        begin
            res_c = res_w;
        end
        d_val = D_W'(res_c - RES_W'(1));
    end

    assign busy = 1'b0;

    // valid bit per stage
    logic [LATENCY-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], start & ~busy};
        end
    end

    // ---------------- stage 1: capture ----------------
    grid_item_t in_reg;

    always_ff @(posedge clk)
    begin
        in_reg <= grid_item;
    end

    // ---------------- stage 2: clamp, numerators ----------------
    logic [D_W-1:0] u_c;
    logic [D_W-1:0] v_c;
    logic [N_W-1:0] num_u_reg;
    logic [N_W-1:0] num_v_reg;
    logic [N_W-1:0] num_t_reg;

    always_comb
    begin
        u_c = (CMP_W'(in_reg.u_index) > CMP_W'(d_val)) ? d_val : D_W'(in_reg.u_index);
        v_c = (CMP_W'(in_reg.v_index) > CMP_W'(d_val)) ? d_val : D_W'(in_reg.v_index);
    end

    always_ff @(posedge clk)
    begin
        num_u_reg <= N_W'({u_c, 16'd0}) + N_W'(d_val >> 1);
        num_v_reg <= N_W'({v_c, 16'd0}) + N_W'(d_val >> 1);
        // polar span: half turn, or quarter turn for a hemisphere
        num_t_reg <= (hemi_reg ? N_W'({v_c, 14'd0}) : N_W'({v_c, 15'd0}))
                     + N_W'(d_val >> 1);
    end

    // ---------------- fraction dividers ----------------
    logic [FRAC_W-1:0] uf;
    logic [FRAC_W-1:0] vf;
    logic [FRAC_W-1:0] tp;

    uvs_div #(.D_W(D_W), .Q_W(FRAC_W)) u_div_u
    (
        .clk (clk),
        .num (num_u_reg),
        .den (d_val),
        .quo (uf)
    );

    uvs_div #(.D_W(D_W), .Q_W(FRAC_W)) u_div_v
    (
        .clk (clk),
        .num (num_v_reg),
        .den (d_val),
        .quo (vf)
    );

    uvs_div #(.D_W(D_W), .Q_W(FRAC_W)) u_div_t
    (
        .clk (clk),
        .num (num_t_reg),
        .den (d_val),
        .quo (tp)
    );

    // texture fractions ride along to the output stage
    logic [FRAC_W-1:0] uf_pipe_reg [POST_STAGES-1];
    logic [FRAC_W-1:0] vf_pipe_reg [POST_STAGES-1];

    always_ff @(posedge clk)
    begin
        uf_pipe_reg[0] <= uf;
        vf_pipe_reg[0] <= vf;
        for (int i = 1; i < POST_STAGES - 1; i++)
        begin
            uf_pipe_reg[i] <= uf_pipe_reg[i-1];
            vf_pipe_reg[i] <= vf_pipe_reg[i-1];
        end
    end

    // ---------------- sine lanes ----------------
    // lane 0 sin(phi), 1 cos(phi), 2 sin(theta), 3 cos(theta)
    logic [PHASE_W-1:0] phase [4];

    always_comb
    begin
        phase[0] = uf[PHASE_W-1:0];
        phase[1] = uf[PHASE_W-1:0] + PHASE_W'(QUARTER);
        phase[2] = tp[PHASE_W-1:0];
        phase[3] = tp[PHASE_W-1:0] + PHASE_W'(QUARTER);
    end

    logic [QTR_W:0]     rr_reg  [4][6];   // folded quarter-wave position
    logic               ng_reg  [4][7];   // lower half-turn: negate
    logic [30:0]        x2_reg  [4][4];   // x^2, Q30
    logic [30:0]        acc_reg [4][4];   // Horner accumulator, Q30
    logic [30:0]        mag_reg [4];
    logic signed [31:0] sn_reg  [4];

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        logic [1:0]        quad;
        logic [QTR_W:0]    r_fold;
        logic [29:0]       r_sq;
        logic [61:0]       h_prod [4];
        logic [45:0]       f_prod;

        always_comb
        begin
            quad   = phase[l][PHASE_W-1:QTR_W];
            r_fold = quad[0] ? ((QTR_W+1)'(QUARTER) - (QTR_W+1)'(phase[l][QTR_W-1:0]))
                             : (QTR_W+1)'(phase[l][QTR_W-1:0]);
            // (r << 16)^2 >> 30 is exactly r^2 << 2
            r_sq   = 30'(rr_reg[l][0]) * 30'(rr_reg[l][0]);
            h_prod[0] = 62'(SIN_C9) * 62'(x2_reg[l][0]);
            for (int j = 1; j < 4; j++)
            begin
                h_prod[j] = 62'(acc_reg[l][j-1]) * 62'(x2_reg[l][j]);
            end
            // acc * (r << 16) >> 30 is exactly acc * r >> 14
            f_prod = 46'(acc_reg[l][3]) * 46'(rr_reg[l][5]);
        end

        always_ff @(posedge clk)
        begin
            rr_reg[l][0] <= r_fold;
            ng_reg[l][0] <= quad[1];
            for (int k = 1; k < 6; k++)
            begin
                rr_reg[l][k] <= rr_reg[l][k-1];
            end
            for (int k = 1; k < 7; k++)
            begin
                ng_reg[l][k] <= ng_reg[l][k-1];
            end
            x2_reg[l][0] <= {r_sq[28:0], 2'b00};
            for (int k = 1; k < 4; k++)
            begin
                x2_reg[l][k] <= x2_reg[l][k-1];
            end
            for (int j = 0; j < 4; j++)
            begin
                acc_reg[l][j] <= HORNER_C[j] - 31'(h_prod[j] >> 30);
            end
            mag_reg[l] <= 31'(f_prod >> 14);
            sn_reg[l]  <= ng_reg[l][6] ? -$signed({1'b0, mag_reg[l]})
                                       : $signed({1'b0, mag_reg[l]});
        end
    end

    // ---------------- direction, position, normal ----------------
    logic signed [63:0] pdx_reg;
    logic signed [63:0] pdy_reg;
    logic signed [31:0] dz_reg;
    logic signed [31:0] dir_reg [3];
    logic signed [63:0] pr_reg  [3];
    logic signed [15:0] nrm_reg [3];
    vertex_t            vertex_reg;

    always_ff @(posedge clk)
    begin
        pdx_reg <= sn_reg[2] * sn_reg[1];
        pdy_reg <= sn_reg[2] * sn_reg[0];
        dz_reg  <= sn_reg[3];

        dir_reg[0] <= 32'(round_shr(pdx_reg, 30));
        dir_reg[1] <= 32'(round_shr(pdy_reg, 30));
        dir_reg[2] <= dz_reg;

        for (int i = 0; i < 3; i++)
        begin
            pr_reg[i]  <= $signed({1'b0, radius_reg}) * dir_reg[i];
            nrm_reg[i] <= sat_q15(round_shr({{32{dir_reg[i][31]}}, dir_reg[i]}, 15));
        end

        vertex_reg.pos_x  <= cx_reg + 32'(round_shr(pr_reg[0], 30));
        vertex_reg.pos_y  <= cy_reg + 32'(round_shr(pr_reg[1], 30));
        vertex_reg.pos_z  <= cz_reg + 32'(round_shr(pr_reg[2], 30));
        vertex_reg.norm_x <= nrm_reg[0];
        vertex_reg.norm_y <= nrm_reg[1];
        vertex_reg.norm_z <= nrm_reg[2];
        vertex_reg.tex_u  <= 17'(ONE_Q16) - 17'(uf_pipe_reg[POST_STAGES-2]);
        vertex_reg.tex_v  <= 17'(vf_pipe_reg[POST_STAGES-2]);
    end

    assign done   = vld_reg[LATENCY-1];
    assign vertex = vertex_reg;

endmodule

// ===== sv/uvs_checker.sv =====
module uvs_checker
    import uvs_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input vertex_t vertex
);

    // every accepted item comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item accepted without a result after the pipeline latency");

    // no result without an item accepted the pipeline latency earlier
    a_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    // texture coordinates stay within 0..1.0
    a_tex: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (vertex.tex_u <= 17'd65536 && vertex.tex_v <= 17'd65536))
        else $error("texture coordinate above 1.0");

endmodule

bind uv_sphere_vertex_eval uvs_checker u_uvs_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .vertex (vertex)
);
